[rtl/core/gost64_pkg.sv]
// ============================================================================
// gost64_pkg
// Shared types, constants and round helpers for the 64-bit GOST block cipher.
// ============================================================================
package gost64_pkg;

   localparam int BLOCK_W   = 64;
   localparam int HALF_W    = 32;
   localparam int NUM_KEYS  = 8;
   localparam int KEY_IDX_W = 3;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_ROUNDS = 32;
   localparam int ROT_AMT   = 11;
   // rounds that walk the keys upward before the descending tail
   localparam int ENC_FWD_ROUNDS = 24;
   localparam int DEC_FWD_ROUNDS = 8;

   // per-stage control that travels with each word
   typedef struct packed {
      logic valid;
      logic mode;   // 1 = decrypt
   } gost64_ctrl_type;

   typedef logic [3:0] nibble_type;

   // substitution rows, row i serves nibble i (nibble 0 is least significant)
   localparam nibble_type SBOX [NUM_KEYS][16] = '{
      '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
        4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
      '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
        4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
      '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
        4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
      '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
        4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
      '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
        4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
      '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
        4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
        4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
      '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
        4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
   };

   // key schedule: ascending for the forward rounds, then 7 down to 0
   function automatic logic [KEY_IDX_W-1:0] key_idx(input int rnd, input logic dec);
      logic [KEY_IDX_W-1:0] low;
      int                   fwd;
      low = KEY_IDX_W'(rnd);
      fwd = dec ? DEC_FWD_ROUNDS : ENC_FWD_ROUNDS;
      return (rnd < fwd) ? low : ~low;
   endfunction

endpackage

[rtl/core/gost64_round.sv]
// ============================================================================
// gost64_round
// One Feistel round with its pipeline register: key add, S-box, rotate, XOR.
// ============================================================================
module gost64_round (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [gost64_pkg::HALF_W-1:0] key_enc,
   input  logic [gost64_pkg::HALF_W-1:0] key_dec,
   input  gost64_pkg::gost64_ctrl_type   ctrl_i,
   input  logic [gost64_pkg::HALF_W-1:0] left_i,
   input  logic [gost64_pkg::HALF_W-1:0] right_i,
   output gost64_pkg::gost64_ctrl_type   ctrl_o,
   output logic [gost64_pkg::HALF_W-1:0] left_o,
   output logic [gost64_pkg::HALF_W-1:0] right_o
);
   import gost64_pkg::*;

   logic [HALF_W-1:0] key;
   logic [HALF_W-1:0] sum;
   logic [HALF_W-1:0] sub;
   logic [HALF_W-1:0] rot;

   gost64_ctrl_type   ctrl_ff, ctrl_in;
   logic [HALF_W-1:0] left_ff, left_in;
   logic [HALF_W-1:0] right_ff, right_in;

   // round function on the right half
   assign key = ctrl_i.mode ? key_dec : key_enc;
   assign sum = right_i + key;

   always_comb begin
      for (int n = 0; n < NUM_KEYS; n++) begin
         sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
      end
   end

   assign rot = {sub[HALF_W-ROT_AMT-1:0], sub[HALF_W-1:HALF_W-ROT_AMT]};

   // halves swap on the way into the next stage
   always_comb begin
      ctrl_in  = ctrl_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (advance) begin
         ctrl_in  = ctrl_i;
         left_in  = right_i;
         right_in = left_i ^ rot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign ctrl_o  = ctrl_ff;
   assign left_o  = left_ff;
   assign right_o = right_ff;

endmodule

[rtl/core/gost_64bit_block_cipher_top.sv]
// ============================================================================
// gost_64bit_block_cipher_top
// 32-round GOST 28147-89 (Magma) block cipher, one round per pipeline stage.
// ============================================================================
//   channel | ports                              | direction | moves
//   --------+------------------------------------+-----------+------------------
//   req     | req_valid req_stall req_mode       | in        | one block word
//           | req_data_in                        |           |
//   rsp     | rsp_valid rsp_stall rsp_data_out   | out       | one result word
//   csr     | csr_valid csr_ready csr_index      | in        | one round key
//           | csr_wdata                          |           |
//
// One word enters per cycle while req_stall is low. A taken word loads round
// one, then passes 31 round stages and the output register. Throughput is
// set by the round stages, one per clock while the skid slot is empty.
// Reset (synchronous) empties the pipeline and clears all keys to zero. A
// stalled result parks in a skid register; the pipeline freezes and req_stall
// rises only once both output slots are full.
// ============================================================================
module gost_64bit_block_cipher_top (
   input  logic                             clock,
   input  logic                             reset,
   // block input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [gost64_pkg::BLOCK_W-1:0]   req_data_in,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gost64_pkg::BLOCK_W-1:0]   rsp_data_out,
   // key writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gost64_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gost64_pkg::HALF_W-1:0]    csr_wdata
);
   import gost64_pkg::*;

   logic [HALF_W-1:0] key_ff [NUM_KEYS];

   gost64_ctrl_type   ctrl_s  [NUM_ROUNDS+1];
   logic [HALF_W-1:0] left_s  [NUM_ROUNDS+1];
   logic [HALF_W-1:0] right_s [NUM_ROUNDS+1];

   logic              advance;
   logic              rsp_take;
   logic [BLOCK_W-1:0] out_word;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_data_ff, rsp_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [BLOCK_W-1:0] skid_data_ff, skid_data_in;

   // key registers, writes past the last key are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_KEYS))) begin
         key_ff[csr_index[KEY_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // pipeline moves whenever the skid slot is free
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign ctrl_s[0].valid = req_valid;
   assign ctrl_s[0].mode  = req_mode;
   assign left_s[0]       = req_data_in[BLOCK_W-1:HALF_W];
   assign right_s[0]      = req_data_in[HALF_W-1:0];

   // round stages
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      gost64_round u_round (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .key_enc (key_ff[key_idx(r, 1'b0)]),
         .key_dec (key_ff[key_idx(r, 1'b1)]),
         .ctrl_i  (ctrl_s[r]),
         .left_i  (left_s[r]),
         .right_i (right_s[r]),
         .ctrl_o  (ctrl_s[r+1]),
         .left_o  (left_s[r+1]),
         .right_o (right_s[r+1])
      );
   end

   // last round leaves the halves swapped; undo it
   assign out_word = {right_s[NUM_ROUNDS], left_s[NUM_ROUNDS]};

   // output register plus skid slot
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (ctrl_s[NUM_ROUNDS].valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = out_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = out_word;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

[rtl/core/gost64_checker.sv]
// ============================================================================
// gost64_checker
// Port-level checks on the cipher top: reset, output hold, input backpressure.
// ============================================================================
module gost64_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [gost64_pkg::BLOCK_W-1:0] rsp_data_out
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or backpressure active after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out))
      else $error("stalled result word changed");

   // input backpressure only while a result word is waiting
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // backpressure starts only after the output side was stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall without output stall");

   // a stall clears only when the result side takes a word
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> $past(rsp_valid && !rsp_stall))
      else $error("input stall released without result taken");

endmodule

bind gost_64bit_block_cipher_top gost64_checker u_gost64_checker (.*);

[bench/gost_64bit_block_cipher_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// gost_64bit_block_cipher_top_tb
// Self-checking bench for the pipelined Magma cipher. A table of edge blocks
// runs under cleared and all-ones keys. Random blocks and encrypt/decrypt
// round trips follow under several key sets, with random gaps and stalls on
// both channels. Every result word is compared against a behavioral model of
// the 32-round network.
// ============================================================================
module gost_64bit_block_cipher_top_tb;
   import gost64_pkg::*;

   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;

   localparam int ENC_ASCEND   = 24;   // rounds with keys ascending, encrypt
   localparam int DEC_ASCEND   = 8;    // rounds with keys ascending, decrypt
   localparam int CSR_IDX_TOP  = 2**CSR_IDX_W - 1;
   localparam int PIPE_LATENCY = 33;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_BLOCKS = 250;
   localparam int NUM_PHASES   = 6;
   localparam int SHOW_LIMIT   = 10;

   // test parameter set, row n serves nibble n
   localparam logic [3:0] SUBST_ROWS [8][16] = '{
      '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
        4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
      '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
        4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
      '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
        4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
      '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
        4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
      '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
        4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
      '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
        4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
        4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
      '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
        4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
   };

   typedef struct packed {
      logic               mode;
      logic [BLOCK_W-1:0] blk;
   } block_req_type;

   // edge blocks; results come from the model
   localparam int NUM_EDGE = 12;
   localparam block_req_type EDGE_BLOCKS [NUM_EDGE] = '{
      '{MODE_ENC, 64'h0000_0000_0000_0000},
      '{MODE_DEC, 64'h0000_0000_0000_0000},
      '{MODE_ENC, 64'hFFFF_FFFF_FFFF_FFFF},
      '{MODE_DEC, 64'hFFFF_FFFF_FFFF_FFFF},
      '{MODE_ENC, 64'h0000_0000_FFFF_FFFF},
      '{MODE_DEC, 64'hFFFF_FFFF_0000_0000},
      '{MODE_ENC, 64'h8000_0000_0000_0000},
      '{MODE_DEC, 64'h0000_0000_0000_0001},
      '{MODE_ENC, 64'h5555_5555_5555_5555},
      '{MODE_DEC, 64'hAAAA_AAAA_AAAA_AAAA},
      '{MODE_ENC, 64'h0123_4567_89AB_CDEF},
      '{MODE_DEC, 64'hFEDC_BA98_7654_3210}
   };

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic                 req_mode    = 1'b0;
   logic [BLOCK_W-1:0]   req_data_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [BLOCK_W-1:0]   rsp_data_out;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [HALF_W-1:0]    csr_wdata   = '0;

   // bench state
   logic [HALF_W-1:0]  key_shadow [NUM_KEYS];
   logic [HALF_W-1:0]  key_plan [NUM_KEYS];
   logic [BLOCK_W-1:0] pending_blocks [$];
   logic               calm          = 1'b0;   // no gaps or stalls on either side
   int unsigned        hold_req_cnt  = 0;
   int unsigned        hold_seen_cnt = 0;
   int                 hold_left     = 0;
   int unsigned        cycle_count   = 0;
   int                 blocks_sent    = 0;
   int                 blocks_checked = 0;
   int                 key_sets       = 0;
   int                 mismatch_count = 0;

   gost_64bit_block_cipher_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // one round: add key, substitute nibbles, rotate left
   function automatic logic [HALF_W-1:0] round_mix(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] k);
      logic [HALF_W-1:0] sum;
      logic [HALF_W-1:0] sub;
      int                n;
      sum = half + k;
      for (n = 0; n < 8; n++)
         sub[4*n +: 4] = SUBST_ROWS[n][sum[4*n +: 4]];
      return {sub[HALF_W-ROT_AMT-1:0], sub[HALF_W-1:HALF_W-ROT_AMT]};
   endfunction

   // full 32-round network under the shadow keys
   function automatic logic [BLOCK_W-1:0] magma_crypt(input logic mode,
                                                     input logic [BLOCK_W-1:0] blk);
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
      logic [HALF_W-1:0] t;
      int                r;
      int                ki;
      left  = blk[BLOCK_W-1:HALF_W];
      right = blk[HALF_W-1:0];
      for (r = 0; r < NUM_ROUNDS; r++) begin
         if (mode == MODE_DEC)
            ki = (r < DEC_ASCEND) ? r : 7 - (r % 8);
         else
            ki = (r < ENC_ASCEND) ? r % 8 : 7 - (r % 8);
         t     = left ^ round_mix(right, key_shadow[ki]);
         left  = right;
         right = t;
      end
      // undo the swap of the last round
      return {right, left};
   endfunction

   task automatic log_fault(input string msg);
      mismatch_count++;
      if (mismatch_count <= SHOW_LIMIT)
         $display("%s", msg);
   endtask

   // one block word; expectation is queued when the word is taken
   task automatic send_block(input logic mode, input logic [BLOCK_W-1:0] blk);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_data_in <= blk;
      do @(posedge clock); while (req_stall);
      pending_blocks.push_back(magma_crypt(mode, blk));
      blocks_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_KEYS)
         key_shadow[idx] = val;
   endtask

   // write key_plan, plus one write to an unused index somewhere in the batch
   task automatic load_keys();
      int k;
      int spare;
      spare = $urandom_range(NUM_KEYS);
      for (k = 0; k <= NUM_KEYS; k++) begin
         if (k == spare)
            write_csr(CSR_IDX_W'($urandom_range(CSR_IDX_TOP, NUM_KEYS)), $urandom);
         if (k < NUM_KEYS)
            write_csr(CSR_IDX_W'(k), key_plan[k]);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
      key_sets++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_blocks.size() != 0);
   endtask

   // result check and stall for the next cycle
   always @(posedge clock) begin : rsp_side
      logic [BLOCK_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            log_fault($sformatf("unexpected result word %h", rsp_data_out));
         end else begin
            want = pending_blocks.pop_front();
            blocks_checked++;
            if (rsp_data_out !== want)
               log_fault($sformatf("block %0d: data_out expected %h, got %h",
                                   blocks_checked, want, rsp_data_out));
         end
      end
      if (hold_req_cnt != hold_seen_cnt) begin
         hold_seen_cnt <= hold_req_cnt;
         hold_left     <= HOLD_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 30);
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout at cycle %0d, %0d results outstanding",
               cycle_count, pending_blocks.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [BLOCK_W-1:0] blk;
      int                 k;
      int                 n;
      int                 phase;
      int                 guard;
      bit                 hold_done;
      bit                 pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      for (k = 0; k < NUM_KEYS; k++)
         key_shadow[k] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge blocks under the cleared keys
      for (n = 0; n < NUM_EDGE; n++)
         send_block(EDGE_BLOCKS[n].mode, EDGE_BLOCKS[n].blk);
      wait_drained();

      // same blocks with all-ones keys, so every key add with a nonzero half wraps
      for (k = 0; k < NUM_KEYS; k++)
         key_plan[k] = '1;
      load_keys();
      for (n = 0; n < NUM_EDGE; n++)
         send_block(EDGE_BLOCKS[n].mode, EDGE_BLOCKS[n].blk);
      wait_drained();

      // random phases, each under its own key set
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         for (k = 0; k < NUM_KEYS; k++) begin
            case (phase)
               1:       key_plan[k] = '0;
               3:       key_plan[k] = (k % 2 == 1) ? '1 : '0;
               default: key_plan[k] = $urandom;
            endcase
         end
         load_keys();
         calm <= (phase == 2);
         n = 0;
         while (n < PHASE_BLOCKS) begin
            blk = {$urandom, $urandom};
            case ($urandom_range(19))
               0:       blk = '0;
               1:       blk = '1;
               2:       blk[BLOCK_W-1:HALF_W] = '0;
               3:       blk[HALF_W-1:0] = '1;
               default: ;
            endcase
            // long output hold while blocks keep coming: pipeline fills up
            if (phase == 1 && n >= 40 && !hold_done) begin
               hold_req_cnt <= hold_req_cnt + 1;
               hold_done = 1'b1;
            end
            // sender pauses until everything in flight has come out
            if (phase == 3 && n >= 120 && !pause_done) begin
               wait_drained();
               pause_done = 1'b1;
            end
            if ($urandom_range(4) == 0) begin
               // round trip: encrypt, then decrypt the predicted ciphertext
               send_block(MODE_ENC, blk);
               send_block(MODE_DEC, magma_crypt(MODE_ENC, blk));
               n += 2;
            end else begin
               send_block(1'($urandom), blk);
               n++;
            end
         end
         wait_drained();
      end

      // final drain and quiet period
      guard = 0;
      while (pending_blocks.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (pending_blocks.size() != 0)
         log_fault($sformatf("%0d results never arrived", pending_blocks.size()));

      $display("run: %0d blocks sent, %0d results checked, %0d key sets, %0d mismatches",
               blocks_sent, blocks_checked, key_sets, mismatch_count);
      $display("covered: edge blocks, both modes, round trips, unused key index, full backpressure");
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[gost_64bit_block_cipher_top.f]
rtl/core/gost64_pkg.sv
rtl/core/gost64_round.sv
rtl/core/gost_64bit_block_cipher_top.sv
rtl/core/gost64_checker.sv
bench/gost_64bit_block_cipher_top_tb.sv
